[sv/lsfg_pkg.sv]
// Shared types, codes and constants of the LED strip frame generator.
package lsfg_pkg;

    localparam int LED_COUNT_W = 9;
    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 9'd256;

    localparam int INDEX_W = 8;
    localparam int COMP_W  = 8;
    localparam int COLOR_W = 24;
    localparam int WORD_W  = 32;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;

    // Request kinds as they arrive on the input channel.
    localparam logic [1:0] REQ_SET_RGB    = 2'd0;
    localparam logic [1:0] REQ_SET_PACKED = 2'd1;
    localparam logic [1:0] REQ_START      = 2'd2;
    localparam logic [1:0] REQ_ADVANCE    = 2'd3;

    // Commands passed from the front end to the frame engine.
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
    localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;
    localparam logic [7:0]        PIXEL_MARK = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
    } cmd_t;

endpackage

[sv/led_strip_frame_generator_unit.sv]
// Top level of the LED strip frame generator.
//
// The block keeps three color bytes per LED in send order and builds the
// word stream of a clocked LED strip frame: an all-zero start word, then
// for each LED the marker byte 0xFF followed by its three stored bytes, and
// finally an all-ones end word that is flagged with m_tlast. Requests arrive
// as items on the s_ channel, with the request kind on s_tuser (0 set from
// red/green/blue, 1 set from a packed color, 2 start a frame, 3 advance one
// word). Only an advance during a frame produces an item on the m_ channel;
// sets beyond the active LED count are dropped, and a start during a frame
// restarts it. The active LED count is min(led_count, MAX_LEDS); the user
// must write led_count through cfg_we/cfg_wdata only while the block is
// idle, which the block does not enforce. A front end classifies requests
// and places them in a four-entry command queue, so the input keeps flowing
// while a result waits on m_tready. The frame engine behind the queue takes
// one command per cycle for sets and starts, and for start or end words
// while the output is free; after a pixel word it waits for the registered
// store read. The store is cleared at reset by per-entry valid bits, so no
// clearing pass is needed and items are taken right after reset.
module led_strip_frame_generator_unit #(
    parameter int MAX_LEDS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_index [7:0], red [15:8], green [23:16], blue [31:24],
    // packed_color [55:32]
    input  logic [55:0] s_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_word [31:0]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    // Entries of the store that a pixel index can reach.
    localparam int STORE_DEPTH = (MAX_LEDS < 256) ? MAX_LEDS : 256;
    // Largest active count: MAX_LEDS, limited to what the led_count register can hold.
    localparam int COUNT_CAP   = (MAX_LEDS < 511) ? MAX_LEDS : 511;
    localparam logic [lsfg_pkg::LED_COUNT_W-1:0] CAP_N =
        lsfg_pkg::LED_COUNT_W'(COUNT_CAP);

    logic [lsfg_pkg::LED_COUNT_W-1:0] led_count_reg;
    logic [lsfg_pkg::LED_COUNT_W-1:0] active_count;
    lsfg_pkg::cmd_t                   front_cmd;
    lsfg_pkg::cmd_t                   head_cmd;
    logic                             push, pop, not_empty, full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= lsfg_pkg::LED_COUNT_RESET;
        end else if (cfg_we) begin
            led_count_reg <= cfg_wdata;
        end
    end

    assign active_count = (led_count_reg > CAP_N) ? CAP_N : led_count_reg;

    lsfg_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .active_count (active_count),
        .queue_full   (full),
        .push         (push),
        .cmd          (front_cmd)
    );

    lsfg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .full      (full)
    );

    lsfg_engine #(
        .DEPTH (STORE_DEPTH)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_count (active_count),
        .cmd          (head_cmd),
        .cmd_valid    (not_empty),
        .cmd_pop      (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

[sv/lsfg_front.sv]
// Front end: takes request items, classifies them and turns them into commands.
module lsfg_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lsfg_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [lsfg_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic [lsfg_pkg::LED_COUNT_W-1:0]    active_count,
    input  logic                                queue_full,
    output logic                                push,
    output lsfg_pkg::cmd_t                      cmd
);

    logic [lsfg_pkg::INDEX_W-1:0] pixel_index;
    logic [lsfg_pkg::COMP_W-1:0]  red;
    logic [lsfg_pkg::COMP_W-1:0]  green;
    logic [lsfg_pkg::COMP_W-1:0]  blue;
    logic [lsfg_pkg::COLOR_W-1:0] packed_color;
    logic                         in_range;
    logic                         keep;

    assign pixel_index  = s_tdata[7:0];
    assign red          = s_tdata[15:8];
    assign green        = s_tdata[23:16];
    assign blue         = s_tdata[31:24];
    assign packed_color = s_tdata[55:32];

    assign in_range = {1'b0, pixel_index} < active_count;
    assign s_tready = !queue_full;

    always_comb begin
        cmd.index = pixel_index;
        cmd.color = packed_color;
        cmd.kind  = lsfg_pkg::CMD_ADVANCE;
        keep      = 1'b1;
        unique case (s_tuser)
            lsfg_pkg::REQ_SET_RGB: begin
                cmd.kind  = lsfg_pkg::CMD_WRITE;
                cmd.color = {blue, green, red};
                keep      = in_range;
            end
            lsfg_pkg::REQ_SET_PACKED: begin
                cmd.kind = lsfg_pkg::CMD_WRITE;
                keep     = in_range;
            end
            lsfg_pkg::REQ_START: begin
                cmd.kind = lsfg_pkg::CMD_START;
            end
            lsfg_pkg::REQ_ADVANCE: begin
                cmd.kind = lsfg_pkg::CMD_ADVANCE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Sets beyond the strip are taken and dropped here.
    assign push = s_tvalid && s_tready && keep;

endmodule

[sv/lsfg_queue.sv]
// Small command queue between the front end and the frame engine.
module lsfg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsfg_pkg::cmd_t push_cmd,
    input  logic           pop,
    output lsfg_pkg::cmd_t head_cmd,
    output logic           not_empty,
    output logic           full
);

    lsfg_pkg::cmd_t                  entry_reg [lsfg_pkg::QUEUE_DEPTH];
    logic [lsfg_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lsfg_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lsfg_pkg::QUEUE_AW:0]     fill_reg, fill_next;

    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign not_empty = fill_reg != '0;
    assign full      = fill_reg == (lsfg_pkg::QUEUE_AW+1)'(lsfg_pkg::QUEUE_DEPTH);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/lsfg_engine.sv]
// Frame engine: pixel store, frame sequencing and the output register.
module lsfg_engine #(
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lsfg_pkg::LED_COUNT_W-1:0] active_count,
    input  lsfg_pkg::cmd_t                   cmd,
    input  logic                             cmd_valid,
    output logic                             cmd_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsfg_pkg::WORD_W-1:0]      m_tdata,
    output logic                             m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [lsfg_pkg::LED_COUNT_W-1:0] DEPTH_N = lsfg_pkg::LED_COUNT_W'(DEPTH);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_START  = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    logic [lsfg_pkg::COLOR_W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0]                 valid_reg;
    logic [lsfg_pkg::COLOR_W-1:0]     rd_data_reg;
    logic                             rd_hit_reg;
    logic                             rd_pend_reg;

    logic [1:0]                       phase_reg, phase_next;
    logic [lsfg_pkg::LED_COUNT_W-1:0] pos_reg, pos_next;
    logic [lsfg_pkg::LED_COUNT_W-1:0] pos_inc;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic                             out_free;
    logic                             wr_en, rd_issue, emit, emit_last;
    logic [lsfg_pkg::WORD_W-1:0]      emit_word;

    logic                             out_valid_reg;
    logic [lsfg_pkg::WORD_W-1:0]      out_word_reg;
    logic                             out_last_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign cmd_pop  = cmd_valid && !rd_pend_reg &&
                      (cmd.kind != lsfg_pkg::CMD_ADVANCE || out_free);
    assign pos_inc  = pos_reg + 1'b1;
    assign rd_addr  = pos_reg[AW-1:0];
    assign wr_addr  = cmd.index[AW-1:0];

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        rd_issue   = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_word  = lsfg_pkg::START_WORD;
        if (cmd_pop) begin
            unique case (cmd.kind)
                lsfg_pkg::CMD_WRITE: begin
                    wr_en = 1'b1;
                end
                lsfg_pkg::CMD_START: begin
                    phase_next = PH_START;
                    pos_next   = '0;
                end
                lsfg_pkg::CMD_ADVANCE: begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                        end
                        PH_START: begin
                            emit       = 1'b1;
                            pos_next   = '0;
                            phase_next = (active_count == '0) ? PH_END : PH_PIXELS;
                        end
                        PH_PIXELS: begin
                            if (pos_reg < active_count) begin
                                rd_issue = 1'b1;
                                pos_next = pos_inc;
                                if (pos_inc >= active_count) begin
                                    phase_next = PH_END;
                                end
                            end else begin
                                emit       = 1'b1;
                                emit_last  = 1'b1;
                                emit_word  = lsfg_pkg::END_WORD;
                                phase_next = PH_IDLE;
                                pos_next   = '0;
                            end
                        end
                        PH_END: begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            emit_word  = lsfg_pkg::END_WORD;
                            phase_next = PH_IDLE;
                            pos_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            rd_pend_reg <= rd_issue;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_pend_reg || emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pixel store. An entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cmd.color;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr] && (pos_reg < DEPTH_N);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            out_word_reg <= {lsfg_pkg::PIXEL_MARK,
                             rd_hit_reg ? rd_data_reg : {lsfg_pkg::COLOR_W{1'b0}}};
            out_last_reg <= 1'b0;
        end else if (emit) begin
            out_word_reg <= emit_word;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sv/lsfg_checker.sv]
// Port-level checks of the LED strip frame generator and their binding.
module lsfg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result item holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // No result item is shown in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // The flagged word is always the all-ones end word.
    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 32'hFFFF_FFFF)
        else $error("last word is not the end word");

    // Every other word is the start word or carries the pixel marker byte.
    a_body_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata == 32'h0 || m_tdata[31:24] == 8'hFF)
        else $error("malformed frame word");

endmodule

bind led_strip_frame_generator_unit lsfg_checker u_lsfg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
